// ===== rtl/core/tcc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tcc_pkg;

  // Console geometry defaults
  localparam int COLUMNS_DEF  = 50;
  localparam int ROWS_DEF     = 20;
  localparam int TAB_STOP_DEF = 4;

  // Field widths
  localparam int FUNC_W  = 2;
  localparam int CHAR_W  = 8;
  localparam int COLOR_W = 8;
  localparam int COL_W   = 6;
  localparam int ROW_W   = 5;
  localparam int KIND_W  = 2;

  // Function codes
  localparam logic [FUNC_W-1:0] FUNC_SET   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_PRINT = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_END   = 2'd2;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_DRAW   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SCROLL = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REPORT = 2'd2;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0a;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0d;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  // Controller to datapath
  typedef struct packed {
    logic load_item;
    logic set_cursor;
    logic draw;
    logic col_clr;
    logic line_down;
    logic report;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              is_tab;
    logic              is_lf;
    logic              is_cr;
    logic              wrap;
    logic              tab_hit;
    logic              row_bottom;
    logic              slot_free;
  } status_t;

endpackage

`default_nettype wire

// ===== rtl/core/tcc_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface tcc_in_if
  import tcc_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [FUNC_W-1:0]  func;
  logic [CHAR_W-1:0]  ch;
  logic [COLOR_W-1:0] fg_color;
  logic [COLOR_W-1:0] bg_color;
  logic [COL_W-1:0]   set_col;
  logic [ROW_W-1:0]   set_row;

  modport source (output valid, func, ch, fg_color, bg_color, set_col, set_row,
                  input ready);
  modport sink (input valid, func, ch, fg_color, bg_color, set_col, set_row,
                output ready);
endinterface

interface tcc_out_if
  import tcc_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [CHAR_W-1:0]  glyph;
  logic [COLOR_W-1:0] draw_fg;
  logic [COLOR_W-1:0] draw_bg;
  logic [COL_W-1:0]   col;
  logic [ROW_W-1:0]   row;
  logic               last;

  modport source (output valid, kind, glyph, draw_fg, draw_bg, col, row, last,
                  input ready);
  modport sink (input valid, kind, glyph, draw_fg, draw_bg, col, row, last,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/core/text_console_cursor_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Cursor engine for a character-cell console. Each input transfer sets the
// cursor, prints one character or ends a string, and produces a sequence of
// results (draw glyph, scroll up, cursor report) ending with a report flagged
// by last. Items are handled one at a time: a transfer is taken only while
// the controller is idle, then the EXEC state decodes it and each following
// cycle emits at most one result into the single output register; a row step
// that does not scroll emits nothing, and a stalled output side holds emission.
// A new item can be taken while the last report still waits in the output
// register.
module text_console_cursor_engine
  import tcc_pkg::*;
#(
  parameter int COLUMNS  = COLUMNS_DEF,
  parameter int ROWS     = ROWS_DEF,
  parameter int TAB_STOP = TAB_STOP_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  tcc_in_if.sink    in_i,
  tcc_out_if.source out_o
);

  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  assign in_i.ready = in_ready;

  tcc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tcc_dp #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_STOP (TAB_STOP)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .func_i      (in_i.func),
    .ch_i        (in_i.ch),
    .fg_color_i  (in_i.fg_color),
    .bg_color_i  (in_i.bg_color),
    .set_col_i   (in_i.set_col),
    .set_row_i   (in_i.set_row),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .kind_o      (out_o.kind),
    .glyph_o     (out_o.glyph),
    .draw_fg_o   (out_o.draw_fg),
    .draw_bg_o   (out_o.draw_bg),
    .col_o       (out_o.col),
    .row_o       (out_o.row),
    .last_o      (out_o.last)
  );

endmodule

`default_nettype wire

// ===== rtl/core/tcc_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tcc_ctrl
  import tcc_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire status_t status_i,
  output cmd_t         cmd_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_EXEC   = 3'd1;
  localparam logic [2:0] ST_DRAW   = 3'd2;
  localparam logic [2:0] ST_NL     = 3'd3;
  localparam logic [2:0] ST_REPORT = 3'd4;

  logic [2:0] state_q, state_d;
  logic       nl_left_q, nl_left_d;

  always_comb begin
    state_d    = state_q;
    nl_left_d  = nl_left_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (status_i.func)
          FUNC_SET: begin
            cmd_o.set_cursor = 1'b1;
            state_d          = ST_REPORT;
          end
          FUNC_PRINT: begin
            if (status_i.is_lf) begin
              cmd_o.col_clr = 1'b1;
              nl_left_d     = 1'b0;
              state_d       = ST_NL;
            end else if (status_i.is_cr) begin
              state_d = ST_REPORT;
            end else begin
              state_d = ST_DRAW;
            end
          end
          FUNC_END: begin
            nl_left_d = 1'b1;
            state_d   = ST_NL;
          end
          default: state_d = ST_REPORT;
        endcase
      end
      ST_DRAW: begin
        if (status_i.slot_free) begin
          cmd_o.draw = 1'b1;
          if (status_i.wrap) begin
            // wrap lands on column zero, which also ends a tab
            nl_left_d = 1'b0;
            state_d   = ST_NL;
          end else if (!status_i.is_tab || status_i.tab_hit) begin
            state_d = ST_REPORT;
          end
        end
      end
      ST_NL: begin
        // a row step emits nothing; only a scroll needs the output slot
        if (status_i.slot_free || !status_i.row_bottom) begin
          cmd_o.line_down = 1'b1;
          if (nl_left_q) begin
            nl_left_d = 1'b0;
          end else begin
            state_d = ST_REPORT;
          end
        end
      end
      ST_REPORT: begin
        if (status_i.slot_free) begin
          cmd_o.report = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      nl_left_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      nl_left_q <= nl_left_d;
    end
  end

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (state_q == ST_IDLE))
    else $error("input taken outside idle");

  a_load_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_item |=> (state_q == ST_EXEC))
    else $error("accepted item not dispatched");

  a_report_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.report |=> (state_q == ST_IDLE) && !nl_left_q)
    else $error("report did not close the item");

endmodule

`default_nettype wire

// ===== rtl/core/tcc_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tcc_dp
  import tcc_pkg::*;
#(
  parameter int COLUMNS  = COLUMNS_DEF,
  parameter int ROWS     = ROWS_DEF,
  parameter int TAB_STOP = TAB_STOP_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire cmd_t               cmd_i,
  output status_t                 status_o,
  input  wire logic [FUNC_W-1:0]  func_i,
  input  wire logic [CHAR_W-1:0]  ch_i,
  input  wire logic [COLOR_W-1:0] fg_color_i,
  input  wire logic [COLOR_W-1:0] bg_color_i,
  input  wire logic [COL_W-1:0]   set_col_i,
  input  wire logic [ROW_W-1:0]   set_row_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [KIND_W-1:0]       kind_o,
  output logic [CHAR_W-1:0]       glyph_o,
  output logic [COLOR_W-1:0]      draw_fg_o,
  output logic [COLOR_W-1:0]      draw_bg_o,
  output logic [COL_W-1:0]        col_o,
  output logic [ROW_W-1:0]        row_o,
  output logic                    last_o
);

  localparam int CW  = $clog2(COLUMNS);
  localparam int RW  = (ROWS > 2) ? $clog2(ROWS) : 1;
  localparam int SCW = (CW > COL_W) ? CW : COL_W;
  localparam int SRW = (RW > ROW_W) ? RW : ROW_W;

  // Latched item
  logic [FUNC_W-1:0]  func_q;
  logic [CHAR_W-1:0]  ch_q;
  logic [COLOR_W-1:0] fg_q, bg_q;
  logic [COL_W-1:0]   scol_q;
  logic [ROW_W-1:0]   srow_q;

  // Cursor
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;

  // Output register
  logic               out_valid_q;
  logic [KIND_W-1:0]  kind_q;
  logic [CHAR_W-1:0]  glyph_q;
  logic [COLOR_W-1:0] draw_fg_q, draw_bg_q;
  logic [COL_W-1:0]   ocol_q;
  logic [ROW_W-1:0]   orow_q;
  logic               last_q;

  logic [CW:0]   col_inc;
  logic          wrap;
  logic [CW-1:0] adv_col;
  logic          tab_hit;
  logic          row_bottom;
  logic          slot_free;
  logic          scroll_emit;
  logic          emit;
  logic [CW-1:0] sat_col;
  logic [RW-1:0] sat_row;

  assign col_inc    = {1'b0, col_q} + (CW+1)'(1);
  assign wrap       = col_inc >= (CW+1)'(COLUMNS);
  assign adv_col    = wrap ? '0 : col_inc[CW-1:0];
  assign row_bottom = (row_q == RW'(ROWS - 1));
  assign slot_free  = !out_valid_q || out_ready_i;
  assign scroll_emit = cmd_i.line_down && row_bottom;
  assign emit       = cmd_i.draw || cmd_i.report || scroll_emit;

  // Tab stops: parallel compare against each multiple of the stop width
  always_comb begin
    tab_hit = 1'b0;
    for (int k = 0; k < COLUMNS; k += TAB_STOP) begin
      if (adv_col == CW'(k)) tab_hit = 1'b1;
    end
  end

  assign sat_col = (SCW'(scol_q) > SCW'(COLUMNS - 1)) ? CW'(COLUMNS - 1) : CW'(scol_q);
  assign sat_row = (SRW'(srow_q) > SRW'(ROWS - 1)) ? RW'(ROWS - 1) : RW'(srow_q);

  always_comb begin
    status_o            = '0;
    status_o.func       = func_q;
    status_o.is_tab     = (ch_q == CH_TAB);
    status_o.is_lf      = (ch_q == CH_LF);
    status_o.is_cr      = (ch_q == CH_CR);
    status_o.wrap       = wrap;
    status_o.tab_hit    = tab_hit;
    status_o.row_bottom = row_bottom;
    status_o.slot_free  = slot_free;
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cmd_i.set_cursor) begin
      col_d = sat_col;
      row_d = sat_row;
    end
    if (cmd_i.draw) col_d = adv_col;
    if (cmd_i.col_clr) col_d = '0;
    if (cmd_i.line_down && !row_bottom) row_d = row_q + RW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      func_q <= func_i;
      ch_q   <= ch_i;
      fg_q   <= fg_color_i;
      bg_q   <= bg_color_i;
      scol_q <= set_col_i;
      srow_q <= set_row_i;
    end
    if (emit) begin
      kind_q    <= cmd_i.draw ? KIND_DRAW : (cmd_i.report ? KIND_REPORT : KIND_SCROLL);
      glyph_q   <= cmd_i.draw ? ((ch_q == CH_TAB) ? CH_SPACE : ch_q) : '0;
      draw_fg_q <= cmd_i.draw ? fg_q : '0;
      draw_bg_q <= cmd_i.draw ? bg_q : '0;
      ocol_q    <= scroll_emit ? '0 : COL_W'(col_q);
      orow_q    <= ROW_W'(row_q);
      last_q    <= cmd_i.report;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign glyph_o     = glyph_q;
  assign draw_fg_o   = draw_fg_q;
  assign draw_bg_o   = draw_bg_q;
  assign col_o       = ocol_q;
  assign row_o       = orow_q;
  assign last_o      = last_q;

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, col_q} < (CW+1)'(COLUMNS))
    else $error("cursor column out of range");

  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, row_q} < (RW+1)'(ROWS))
    else $error("cursor row out of range");

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_i.draw, cmd_i.report, scroll_emit}))
    else $error("two results in one cycle");

  a_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> slot_free)
    else $error("result overwrote a pending transfer");

endmodule

`default_nettype wire
